>>> src/fsrd_pkg.sv
// Package for the flippable stack on a ring deque.
// Holds the sizes, the operation and status codes, the controller state type
// and the command struct. No dependencies.
`default_nettype none

package fsrd_pkg;

    // Storage size and data width
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [PTR_W-1:0]             ptr_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    // Operation codes carried by func; the fourth code is a no-op
    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_FLIP = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;
        logic load;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/fsrd_in_if.sv
// Request channel: one operation per item.
// Depends on fsrd_pkg.
`default_nettype none

interface fsrd_in_if;
    import fsrd_pkg::*;

    logic         valid;
    logic         ready;
    logic [1:0]   func;
    data_t        push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

`default_nettype wire

>>> src/fsrd_out_if.sv
// Result channel: one item per operation.
// Depends on fsrd_pkg.
`default_nettype none

interface fsrd_out_if;
    import fsrd_pkg::*;

    logic         valid;
    logic         ready;
    data_t        top_value;
    logic         is_empty;
    logic [1:0]   status;
    logic         orientation;

    modport source (output valid, output top_value, output is_empty, output status,
                    output orientation, input ready);
    modport sink   (input valid, input top_value, input is_empty, input status,
                    input orientation, output ready);
endinterface

`default_nettype wire

>>> src/fsrd_ctrl.sv
// Controller: sequences each item through execute and result load, and owns
// the result valid flag. Depends on fsrd_pkg.
`default_nettype none

module fsrd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fsrd_pkg::cmd_t     cmd
);
    import fsrd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    // The result register may be refilled when empty or being emptied now
    assign can_load = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            ST_LOAD:
            begin
                cmd.load = can_load;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fsrd_datapath.sv
// Datapath: slot storage, ring pointers, occupancy, orientation and the
// result register. Depends on fsrd_pkg.
`default_nettype none

module fsrd_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fsrd_pkg::cmd_t  cmd,
    input  wire logic [1:0]      func,
    input  wire fsrd_pkg::data_t push_value,
    output fsrd_pkg::data_t      top_value,
    output logic                 is_empty,
    output logic [1:0]           status,
    output logic                 orientation
);
    import fsrd_pkg::*;

    localparam ptr_t PTR_LAST = ptr_t'(DEPTH - 1);
    localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

    data_t   slot_reg [DEPTH];
    ptr_t    front_reg;
    ptr_t    front_next;
    ptr_t    rear_reg;
    ptr_t    rear_next;
    cnt_t    occ_reg;
    cnt_t    occ_next;
    logic    inv_reg;
    logic    inv_next;
    status_t op_status_reg;
    status_t op_status_next;
    logic    wr_en;
    ptr_t    wr_ptr;

    data_t   top_value_reg;
    logic    is_empty_reg;
    status_t status_reg;
    logic    orientation_reg;

    ptr_t    front_dec;
    ptr_t    front_inc;
    ptr_t    rear_dec;
    ptr_t    rear_inc;
    ptr_t    top_ptr;

    // Wrapping pointer steps
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - ptr_t'(1);
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + ptr_t'(1);
    assign rear_dec  = (rear_reg == '0) ? PTR_LAST : rear_reg - ptr_t'(1);
    assign rear_inc  = (rear_reg == PTR_LAST) ? '0 : rear_reg + ptr_t'(1);

    // Operation decode and state update
    always_comb
    begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        occ_next       = occ_reg;
        inv_next       = inv_reg;
        op_status_next = op_status_reg;
        wr_en          = 1'b0;
        wr_ptr         = '0;
        if (cmd.exec)
        begin
            op_status_next = STATUS_OK;
            case (func)
                FUNC_PUSH:
                begin
                    if (occ_reg == CNT_FULL)
                    begin
                        op_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        occ_next = occ_reg + cnt_t'(1);
                        if (occ_reg == '0)
                        begin
                            // First item of an empty stack always lands in slot zero
                            front_next = '0;
                            rear_next  = '0;
                            wr_ptr     = '0;
                        end
                        else if (!inv_reg)
                        begin
                            front_next = front_dec;
                            wr_ptr     = front_dec;
                        end
                        else
                        begin
                            rear_next = rear_inc;
                            wr_ptr    = rear_inc;
                        end
                    end
                end
                FUNC_POP:
                begin
                    if (occ_reg == '0)
                    begin
                        op_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        occ_next = occ_reg - cnt_t'(1);
                        // Popping the last item leaves the pointers where they are
                        if (occ_reg != cnt_t'(1))
                        begin
                            if (!inv_reg)
                            begin
                                front_next = front_inc;
                            end
                            else
                            begin
                                rear_next = rear_dec;
                            end
                        end
                    end
                end
                FUNC_FLIP:
                begin
                    inv_next = !inv_reg;
                end
                default:
                begin
                    op_status_next = STATUS_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
            inv_reg   <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            occ_reg   <= occ_next;
            inv_reg   <= inv_next;
        end
    end

    // Slot storage and the status of the item in flight
    always_ff @(posedge clk)
    begin
        op_status_reg <= op_status_next;
        if (wr_en)
        begin
            slot_reg[wr_ptr] <= push_value;
        end
    end

    // Result register, loaded from the updated state
    assign top_ptr = inv_reg ? rear_reg : front_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            top_value_reg   <= (occ_reg == '0) ? '1 : slot_reg[top_ptr];
            is_empty_reg    <= (occ_reg == '0);
            status_reg      <= op_status_reg;
            orientation_reg <= inv_reg;
        end
    end

    assign top_value   = top_value_reg;
    assign is_empty    = is_empty_reg;
    assign status      = status_reg;
    assign orientation = orientation_reg;

endmodule

`default_nettype wire

>>> src/flippable_stack_on_ring_deque.sv
// Top level of the flippable stack on a ring deque.
// Depends on fsrd_pkg, fsrd_in_if, fsrd_out_if, fsrd_ctrl and fsrd_datapath.
`default_nettype none

// A stack of DEPTH signed items kept in a ring of slots, with an orientation
// bit that reverses it in one operation. Each request (push, pop or flip)
// returns exactly one item: the top after the operation (all ones when the
// stack is empty), an empty flag, a status (ok, push rejected because full,
// or pop on empty) and the orientation. A request is handled in two steps: the
// pointers, count and slot are updated, then the new top is read from the slots
// into the result register once that is free. A new request is taken only after
// the last one has been loaded; a result waiting in the result register does
// not stop the next request from being taken, only from being loaded. Func
// code three changes nothing and reports the current state.

module flippable_stack_on_ring_deque (
    input  wire logic clk,
    input  wire logic rst_n,
    fsrd_in_if.sink   req,
    fsrd_out_if.source rsp
);
    import fsrd_pkg::*;

    cmd_t cmd;

    // Sequencing
    fsrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Storage and result
    fsrd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (req.func),
        .push_value  (req.push_value),
        .top_value   (rsp.top_value),
        .is_empty    (rsp.is_empty),
        .status      (rsp.status),
        .orientation (rsp.orientation)
    );

endmodule

`default_nettype wire
